### hdl/pfdm_pkg.sv
// pfdm_pkg: shared constants, types and codes for the pwm frequency / duty meter
// used by pfdm_capture, pfdm_div and pwm_frequency_duty_meter; no dependencies
`timescale 1ns / 1ps

package pfdm_pkg;

    // capture field widths
    localparam int STAMP_BITS     = 16;
    localparam int TICK_BITS      = 25;
    localparam int FREQ_BITS      = 17;
    localparam int DUTY_BITS      = 7;

    // serial divider sizing: numerator holds tick_hz + period * 50,
    // divisor holds period * 100
    localparam int DIV_NUM_BITS   = 26;
    localparam int DIV_DEN_BITS   = 23;
    localparam int DIV_CNT_BITS   = $clog2(DIV_NUM_BITS);

    localparam logic [TICK_BITS-1:0]    TICK_HZ_RESET = 25'd16000000;
    localparam logic [DIV_NUM_BITS-1:0] FREQ_MAX      = 26'd100000;

    // capture sequence position
    typedef enum logic [1:0] {
        STG_WAIT_RISE1 = 2'd0,
        STG_WAIT_FALL  = 2'd1,
        STG_WAIT_RISE2 = 2'd2
    } stage_t;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FREQ_GO,
        ST_FREQ_WAIT,
        ST_DUTY_GO,
        ST_DUTY_WAIT,
        ST_OUT
    } seq_state_t;

    // completed rise / fall / rise sequence from the capture stage
    typedef struct packed {
        logic                  launch;
        logic                  ok;
        logic [STAMP_BITS-1:0] period;
        logic [STAMP_BITS-1:0] high;
    } cap_t;

    // divide request into the serial divider
    typedef struct packed {
        logic                    start;
        logic [DIV_NUM_BITS-1:0] num;
        logic [DIV_DEN_BITS-1:0] den;
    } div_req_t;

    // divider result
    typedef struct packed {
        logic                    done;
        logic [DIV_NUM_BITS-1:0] quo;
    } div_rsp_t;

endpackage

### hdl/pwm_frequency_duty_meter.sv
// pwm_frequency_duty_meter: top level, capture tracking, sequencer, output register
// depends on pfdm_pkg, pfdm_capture, pfdm_div
`timescale 1ns / 1ps

//  channel   | port group        | contents
//  ----------+-------------------+--------------------------------------------------
//  input     | s_axis_*          | tdata: stamp; tuser: edge_rising
//  result    | m_axis_*          | tdata: period, high, freq, duty; tuser: valid_res
//  config    | cfg_wr_*          | tick_hz, written whenever cfg_wr_en is high
//
//  a request that does not complete a rise / fall / rise sequence is not held; the
//  completing rise holds the input until the result enters the output register,
//  directly if the stamps are not increasing, else after a constant-multiply step and
//  two divider passes (frequency then duty); reset (aresetn low at a clock edge) clears
//  the sequence and the result valid flag and loads tick_hz with TICK_HZ_RESET; a
//  stalled result waits in the output register while new requests enter

module pwm_frequency_duty_meter
    import pfdm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] stamp
    input  logic [0:0]  s_axis_tuser,   // [0] edge_rising

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [15:0] period_ticks, [31:16] high_ticks,
                                        // [48:32] freq_tenths_khz, [55:49] duty_percent
    output logic [0:0]  m_axis_tuser,   // [0] valid_res

    input  logic        cfg_wr_en,
    input  logic [24:0] cfg_wr_data     // tick_hz
);

    // config register
    logic [TICK_BITS-1:0] tick_hz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_hz_reg <= TICK_HZ_RESET;
        end else if (cfg_wr_en) begin
            tick_hz_reg <= cfg_wr_data;
        end
    end

    // edge sequence tracking
    cap_t cap;
    logic s_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    pfdm_capture u_capture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .stamp   (s_axis_tdata[STAMP_BITS-1:0]),
        .rising  (s_axis_tuser[0]),
        .cap     (cap)
    );

    // shared serial divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    pfdm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer registers
    seq_state_t               state_reg, state_next;
    logic                     ok_reg, ok_next;
    logic [STAMP_BITS-1:0]    period_reg, period_next;
    logic [STAMP_BITS-1:0]    high_reg, high_next;
    logic [DIV_NUM_BITS-1:0]  fnum_reg, fnum_next;    // tick_hz + period * 50
    logic [DIV_DEN_BITS-1:0]  fden_reg, fden_next;    // period * 100
    logic [DIV_DEN_BITS-1:0]  dnum_reg, dnum_next;    // high * 100
    logic [FREQ_BITS-1:0]     freq_reg, freq_next;
    logic [DUTY_BITS-1:0]     duty_reg, duty_next;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic [55:0]              m_data_reg, m_data_next;
    logic                     m_user_reg, m_user_next;
    logic                     out_free;

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        state_next   = state_reg;
        ok_next      = ok_reg;
        period_next  = period_reg;
        high_next    = high_reg;
        fnum_next    = fnum_reg;
        fden_next    = fden_reg;
        dnum_next    = dnum_reg;
        freq_next    = freq_reg;
        duty_next    = duty_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        div_req      = '0;

        // new requests only while no sequence result is being worked on
        s_axis_tready = (state_reg == ST_IDLE) && !cap.launch;

        unique case (state_reg)
            ST_IDLE: begin
                if (cap.launch) begin
                    ok_next     = cap.ok;
                    period_next = cap.period;
                    high_next   = cap.high;
                    freq_next   = '0;
                    duty_next   = '0;
                    state_next  = cap.ok ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                // constant multiplies, registered ahead of the divider
                fnum_next  = {1'b0, tick_hz_reg}
                           + ({10'b0, period_reg} * 26'd50);
                fden_next  = {7'b0, period_reg} * 23'd100;
                dnum_next  = {7'b0, high_reg} * 23'd100;
                state_next = ST_FREQ_GO;
            end
            ST_FREQ_GO: begin
                div_req.start = 1'b1;
                div_req.num   = fnum_reg;
                div_req.den   = fden_reg;
                state_next    = ST_FREQ_WAIT;
            end
            ST_FREQ_WAIT: begin
                if (div_rsp.done) begin
                    // saturate at 10 MHz
                    freq_next  = (div_rsp.quo > FREQ_MAX) ? FREQ_MAX[FREQ_BITS-1:0]
                                                          : div_rsp.quo[FREQ_BITS-1:0];
                    state_next = ST_DUTY_GO;
                end
            end
            ST_DUTY_GO: begin
                div_req.start = 1'b1;
                div_req.num   = {3'b0, dnum_reg};
                div_req.den   = {7'b0, period_reg};
                state_next    = ST_DUTY_WAIT;
            end
            ST_DUTY_WAIT: begin
                if (div_rsp.done) begin
                    // high < period keeps the quotient below 100
                    duty_next  = div_rsp.quo[DUTY_BITS-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = ok_reg;
                    m_data_next  = ok_reg ? {duty_reg, freq_reg, high_reg, period_reg}
                                          : 56'd0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg     <= ok_next;
        period_reg <= period_next;
        high_reg   <= high_next;
        fnum_reg   <= fnum_next;
        fden_reg   <= fden_next;
        dnum_reg   <= dnum_next;
        freq_reg   <= freq_next;
        duty_reg   <= duty_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_user_reg;

endmodule

### hdl/pfdm_capture.sv
// pfdm_capture: edge sequence tracker, keeps r1 and r2 and forms period / high time
// depends on pfdm_pkg
`timescale 1ns / 1ps

module pfdm_capture
    import pfdm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [STAMP_BITS-1:0] stamp,
    input  logic                  rising,
    output cap_t                  cap
);

    stage_t                stage_reg, stage_next;
    logic [STAMP_BITS-1:0] r1_reg, r1_next;
    logic [STAMP_BITS-1:0] r2_reg, r2_next;
    cap_t                  cap_reg, cap_next;

    always_comb begin
        stage_next      = stage_reg;
        r1_next         = r1_reg;
        r2_next         = r2_reg;
        cap_next        = cap_reg;
        cap_next.launch = 1'b0;
        if (accept) begin
            unique case (stage_reg)
                STG_WAIT_FALL: begin
                    if (!rising) begin
                        r2_next    = stamp;
                        stage_next = STG_WAIT_RISE2;
                    end
                end
                STG_WAIT_RISE2: begin
                    if (rising) begin
                        stage_next      = STG_WAIT_RISE1;
                        cap_next.launch = 1'b1;
                        cap_next.ok     = (r1_reg < r2_reg) && (r2_reg < stamp);
                        cap_next.period = stamp - r1_reg;
                        cap_next.high   = r2_reg - r1_reg;
                    end
                end
                default: begin
                    // first rise, also the unused stage code
                    if (rising) begin
                        r1_next    = stamp;
                        stage_next = STG_WAIT_FALL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= STG_WAIT_RISE1;
            r1_reg    <= '0;
            r2_reg    <= '0;
            cap_reg   <= '0;
        end else begin
            stage_reg <= stage_next;
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
            cap_reg   <= cap_next;
        end
    end

    assign cap = cap_reg;

endmodule

### hdl/pfdm_div.sv
// pfdm_div: bit-serial restoring divider, one quotient bit per cycle
// depends on pfdm_pkg
`timescale 1ns / 1ps

module pfdm_div
    import pfdm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_NUM_BITS-1:0] sh_reg, sh_next;     // numerator in, quotient out
    logic [DIV_DEN_BITS-1:0] rem_reg, rem_next;
    logic [DIV_DEN_BITS-1:0] den_reg, den_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [DIV_DEN_BITS:0]   trial;
    logic [DIV_DEN_BITS:0]   diff;
    logic                    fits;

    always_comb begin
        trial     = {rem_reg, sh_reg[DIV_NUM_BITS-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            sh_next   = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            sh_next  = {sh_reg[DIV_NUM_BITS-2:0], fits};
            rem_next = fits ? diff[DIV_DEN_BITS-1:0] : trial[DIV_DEN_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(DIV_NUM_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = sh_reg;

endmodule

### hdl/pfdm_checker.sv
// pfdm_checker: port-level assertions for pwm_frequency_duty_meter, bound to the top level
// depends on pwm_frequency_duty_meter
`timescale 1ns / 1ps

module pfdm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // an invalid result carries all-zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 56'd0)
        else $error("invalid result with nonzero fields");

    // a valid result has a nonzero period longer than its high time
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[15:0] != 16'd0 && m_axis_tdata[31:16] < m_axis_tdata[15:0])
        else $error("valid result with bad period or high time");

    // duty and frequency stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[55:49] < 7'd100
                       && m_axis_tdata[48:32] <= 17'd100000)
        else $error("duty or frequency out of range");

endmodule

bind pwm_frequency_duty_meter pfdm_checker u_pfdm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
